[hw/rtl/assert_macros.svh]
// Assertion macros shared by the longest line finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define LLF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define LLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define LLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/llf_pkg.sv]
// Shared constants, types and helpers of the longest line finder.
package llf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);

  localparam int LEN_W   = 11;
  localparam int COORD_W = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam int WIDTH_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  // One pixel moving from the position stage into the evaluation stage.
  typedef struct packed {
    logic             valid;
    logic             pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last_col;
    logic             last_row;
  } llf_item_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [COORD_W-1:0] first_row;
    logic [COORD_W-1:0] first_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
  } llf_result_t;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    sat_inc = (v == LEN_MAX) ? LEN_MAX : v + LEN_W'(1);
  endfunction

  function automatic logic [WSZ_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      clamp_width = WSZ_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      clamp_width = WSZ_W'(MAX_WIDTH);
    end else begin
      clamp_width = WSZ_W'(v);
    end
  endfunction

  function automatic logic [HSZ_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      clamp_height = HSZ_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      clamp_height = HSZ_W'(MAX_HEIGHT);
    end else begin
      clamp_height = HSZ_W'(v);
    end
  endfunction

endpackage

[hw/rtl/bitmap_longest_line_finder_unit.sv]
// Top level of the bitmap longest line finder.
//
// Pixels enter on the slave stream, one bit a transaction in raster order
// (row by row, left to right). The cfg channel sets direction (0 rows,
// 1 columns), frame width and frame height; it is always ready. The user must
// see it is written only while no pixel is in flight; the block does not check.
// Width and height of 0 act as 1, larger ones saturate to the frame maximum.
// One result leaves on the master stream after the last pixel of each frame:
// found flag and start/end coordinates of the longest run of set pixels.
// A pixel is read from the column length RAM when accepted and evaluated in
// the next cycle; m_axis_tvalid rises once the last pixel of a frame has
// passed the item register and the output register. Pixels inside a frame
// go at one per cycle. The last pixel of a frame is held off while an earlier
// result is still in evaluation or sits in the output register, so a stalled
// receiver stalls the source only at frame end. Reset clears position, run
// counters and best run; the column RAM needs no clearing since row zero
// writes every entry before it is read.
`include "assert_macros.svh"

module bitmap_longest_line_finder_unit import llf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_W-1:0]     s_axis_tdata,  // [0] pixel_set
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] found, [10:1] first_row, [20:11] first_col, [30:21] end_row, [40:31] end_col
  output logic [OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  logic                   vert_q;
  logic [WSZ_W-1:0]       width_q;
  logic [HSZ_W-1:0]       height_q;

  logic                   accept, pos_frame_end;
  logic [COL_W-1:0]       raddr;
  llf_item_t              item;
  logic [LEN_W-1:0]       rdata;
  logic                   mem_we;
  logic [COL_W-1:0]       mem_waddr;
  logic [LEN_W-1:0]       mem_wdata;
  llf_result_t            res;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q   <= 1'b0;
      width_q  <= WSZ_W'(WIDTH_RST);
      height_q <= HSZ_W'(HEIGHT_RST);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIRECTION: vert_q   <= cfg_data_i[0];
        CFG_WIDTH:     width_q  <= clamp_width(cfg_data_i);
        CFG_HEIGHT:    height_q <= clamp_height(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Hold the last pixel of a frame until the output register is sure to be free.
  assign s_axis_tready = !(pos_frame_end && (out_valid_q || res.valid));
  assign accept        = s_axis_tvalid && s_axis_tready;

  llf_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (s_axis_tdata[0]),
    .width_i     (width_q),
    .height_i    (height_q),
    .frame_end_o (pos_frame_end),
    .raddr_o     (raddr),
    .item_o      (item)
  );

  llf_ram #(
    .DATA_W (LEN_W),
    .DEPTH  (MAX_WIDTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  llf_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .vert_i      (vert_q),
    .rdata_i     (rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= {(OUT_TDATA_W - 1 - 4 * COORD_W)'(0), res.end_col, res.end_row,
                     res.first_col, res.first_row, res.found};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `LLF_ASSERT_IMPL(a_out_slot_free, clk_i, rst_ni, res.valid, !out_valid_q || m_axis_tready, "result overwrites a pending transaction")
  `LLF_ASSERT_NEXT(a_end_reaches_eval, clk_i, rst_ni, accept && pos_frame_end, item.valid && item.last_col && item.last_row, "frame end lost in pipeline")

endmodule

[hw/rtl/llf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module llf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/llf_pos.sv]
// Raster position counters and the pipeline register into the evaluation stage.
module llf_pos import llf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             pixel_i,
  input  logic [WSZ_W-1:0] width_i,
  input  logic [HSZ_W-1:0] height_i,
  output logic             frame_end_o,
  output logic [COL_W-1:0] raddr_o,
  output llf_item_t        item_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  llf_item_t        item_q, item_d;
  logic             last_col, last_row;

  assign last_col = (WSZ_W'(col_q) + WSZ_W'(1)) >= width_i;
  assign last_row = (HSZ_W'(row_q) + HSZ_W'(1)) >= height_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col && last_row) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    item_d          = item_q;
    item_d.valid    = accept_i;
    if (accept_i) begin
      item_d.pixel    = pixel_i;
      item_d.col      = col_q;
      item_d.row      = row_q;
      item_d.last_col = last_col;
      item_d.last_row = last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      item_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      item_q <= item_d;
    end
  end

  assign frame_end_o = last_col && last_row;
  assign raddr_o     = col_q;
  assign item_o      = item_q;

endmodule

[hw/rtl/llf_eval.sv]
// Run counting, column entry update and best run tracking for one pixel a cycle.
`include "assert_macros.svh"

module llf_eval import llf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llf_item_t         item_i,
  input  logic              vert_i,
  input  logic [LEN_W-1:0]  rdata_i,
  output logic              mem_we_o,
  output logic [COL_W-1:0]  mem_waddr_o,
  output logic [LEN_W-1:0]  mem_wdata_o,
  output llf_result_t       result_o
);

  logic [LEN_W-1:0]   row_run_q, row_run_d;
  logic [LEN_W-1:0]   best_len_q, best_len_d;
  logic [COORD_W-1:0] best_sr_q, best_sr_d, best_sc_q, best_sc_d;

  logic               fwd_valid_q;
  logic [COL_W-1:0]   fwd_addr_q;
  logic [LEN_W-1:0]   fwd_data_q;

  logic [LEN_W-1:0]   prev, v_inc, h_inc, mem_wdata;
  logic [COORD_W-1:0] r10, c10, end_len;
  logic               cand_ok, take, tie_win, frame_end;
  logic [LEN_W-1:0]   cand_len;
  logic [COORD_W-1:0] cand_sr, cand_sc;

  assign r10 = COORD_W'(item_i.row);
  assign c10 = COORD_W'(item_i.col);

  // Row zero never reads the column store; the last write bypasses the RAM.
  always_comb begin
    if (item_i.row == '0) begin
      prev = '0;
    end else if (fwd_valid_q && (fwd_addr_q == item_i.col)) begin
      prev = fwd_data_q;
    end else begin
      prev = rdata_i;
    end
  end

  assign v_inc = sat_inc(prev);
  assign h_inc = sat_inc(row_run_q);

  // Candidate run that ends at this pixel in the active direction.
  always_comb begin
    cand_ok  = 1'b0;
    cand_len = '0;
    cand_sr  = r10;
    cand_sc  = c10;
    if (!vert_i) begin
      if (item_i.pixel && item_i.last_col) begin
        cand_ok  = 1'b1;
        cand_len = h_inc;
        cand_sc  = c10 + COORD_W'(1) - COORD_W'(h_inc);
      end else if (!item_i.pixel && (row_run_q != '0)) begin
        cand_ok  = 1'b1;
        cand_len = row_run_q;
        cand_sc  = c10 - COORD_W'(row_run_q);
      end
    end else begin
      if (item_i.pixel && item_i.last_row) begin
        cand_ok  = 1'b1;
        cand_len = v_inc;
        cand_sr  = r10 + COORD_W'(1) - COORD_W'(v_inc);
      end else if (!item_i.pixel && (prev != '0)) begin
        cand_ok  = 1'b1;
        cand_len = prev;
        cand_sr  = r10 - COORD_W'(prev);
      end
    end
  end

  // Vertical ties go to the smaller column, then the smaller start row.
  assign tie_win = vert_i && (cand_len == best_len_q) && (cand_len != '0) &&
                   ((cand_sc < best_sc_q) ||
                    ((cand_sc == best_sc_q) && (cand_sr < best_sr_q)));
  assign take      = item_i.valid && cand_ok && ((cand_len > best_len_q) || tie_win);
  assign frame_end = item_i.valid && item_i.last_col && item_i.last_row;

  always_comb begin
    best_len_d = best_len_q;
    best_sr_d  = best_sr_q;
    best_sc_d  = best_sc_q;
    if (take) begin
      best_len_d = cand_len;
      best_sr_d  = cand_sr;
      best_sc_d  = cand_sc;
    end
  end

  always_comb begin
    row_run_d = row_run_q;
    if (item_i.valid) begin
      row_run_d = (item_i.pixel && !item_i.last_col) ? h_inc : '0;
    end
  end

  assign mem_wdata = (item_i.pixel && !item_i.last_row) ? v_inc : '0;

  assign end_len = COORD_W'(best_len_d) - COORD_W'(1);

  always_comb begin
    result_o       = '0;
    result_o.valid = frame_end;
    if (best_len_d != '0) begin
      result_o.found     = 1'b1;
      result_o.first_row = best_sr_d;
      result_o.first_col = best_sc_d;
      // The end point follows the direction in force on the last pixel.
      result_o.end_row   = vert_i ? best_sr_d + end_len : best_sr_d;
      result_o.end_col   = vert_i ? best_sc_d : best_sc_d + end_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_run_q   <= '0;
      best_len_q  <= '0;
      best_sr_q   <= '0;
      best_sc_q   <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      row_run_q   <= row_run_d;
      fwd_valid_q <= item_i.valid;
      if (frame_end) begin
        best_len_q <= '0;
        best_sr_q  <= '0;
        best_sc_q  <= '0;
      end else begin
        best_len_q <= best_len_d;
        best_sr_q  <= best_sr_d;
        best_sc_q  <= best_sc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      fwd_addr_q <= item_i.col;
      fwd_data_q <= mem_wdata;
    end
  end

  assign mem_we_o    = item_i.valid;
  assign mem_waddr_o = item_i.col;
  assign mem_wdata_o = mem_wdata;

  `LLF_ASSERT_IMPL(a_empty_best_clear, clk_i, rst_ni, best_len_q == '0, (best_sr_q == '0) && (best_sc_q == '0), "best start set with zero length")
  `LLF_ASSERT_IMPL(a_last_row_clears, clk_i, rst_ni, item_i.valid && item_i.last_row, mem_wdata == '0, "column entry kept past last row")

endmodule

[sim/bitmap_longest_line_finder_unit_tb.sv]
// Testbench of the bitmap longest line finder: self-checking, with a built-in run predictor.
module bitmap_longest_line_finder_unit_tb;
  import llf_pkg::*;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] first_row;
    logic [COORD_W-1:0] first_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
  } line_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [0] pixel_set
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] found, [10:1] first_row, [20:11] first_col, [30:21] end_row, [40:31] end_col
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  bitmap_longest_line_finder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and run state.
  logic                  dir_mode   = 1'b0;
  logic [CFG_DATA_W-1:0] width_cfg  = CFG_DATA_W'(WIDTH_RST);
  logic [CFG_DATA_W-1:0] height_cfg = CFG_DATA_W'(HEIGHT_RST);
  int unsigned col_pos, row_pos, row_run, best_len, best_row, best_col;
  int unsigned col_run [MAX_WIDTH];

  line_result_t expected_lines [$];
  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int pixels_sent;

  function automatic int unsigned eff_size(input logic [CFG_DATA_W-1:0] raw, input int maxv);
    if (raw == '0) return 1;
    return (int'(raw) > maxv) ? maxv : int'(raw);
  endfunction

  function automatic int unsigned bump_len(input int unsigned len);
    return (len >= int'(LEN_MAX)) ? len : len + 1;
  endfunction

  function automatic void offer_row_run(input int unsigned len, input int unsigned r,
                                        input int unsigned c);
    if (len > best_len) begin
      best_len = len;
      best_row = r % 1024;
      best_col = c % 1024;
    end
  endfunction

  // Column-major tie break: smaller column, then smaller start row.
  function automatic void offer_col_run(input int unsigned len, input int unsigned r,
                                        input int unsigned c);
    bit take;
    take = len > best_len;
    r = r % 1024;
    c = c % 1024;
    if (!take && len == best_len && len != 0)
      take = (c < best_col) || (c == best_col && r < best_row);
    if (take) begin
      best_len = len;
      best_row = r;
      best_col = c;
    end
  endfunction

  // Advance the run state by one pixel; return 1 with the frame's line at frame end.
  function automatic bit track_pixel(input logic p, output line_result_t line);
    int unsigned w, h, c, r, prev, v;
    bit last_c, last_r;
    w = eff_size(width_cfg, MAX_WIDTH);
    h = eff_size(height_cfg, MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    last_c = (c + 1 >= w);
    last_r = (r + 1 >= h);
    line = '0;

    if (p) begin
      row_run = bump_len(row_run);
      if (last_c) begin
        if (!dir_mode) offer_row_run(row_run, r, c + 1 - row_run);
        row_run = 0;
      end
    end else begin
      if (row_run != 0 && !dir_mode) offer_row_run(row_run, r, c - row_run);
      row_run = 0;
    end

    prev = (r == 0) ? 0 : col_run[c];
    if (p) begin
      v = bump_len(prev);
      if (last_r) begin
        if (dir_mode) offer_col_run(v, r + 1 - v, c);
        col_run[c] = 0;
      end else begin
        col_run[c] = v;
      end
    end else begin
      if (prev != 0 && dir_mode) offer_col_run(prev, r - prev, c);
      col_run[c] = 0;
    end

    if (last_c && last_r) begin
      if (best_len != 0) begin
        line.found     = 1'b1;
        line.first_row = COORD_W'(best_row);
        line.first_col = COORD_W'(best_col);
        line.end_row   = COORD_W'(best_row);
        line.end_col   = COORD_W'(best_col);
        if (dir_mode) line.end_row = COORD_W'(best_row + best_len - 1);
        else          line.end_col = COORD_W'(best_col + best_len - 1);
      end
      col_pos  = 0;
      row_pos  = 0;
      row_run  = 0;
      best_len = 0;
      best_row = 0;
      best_col = 0;
      return 1'b1;
    end
    if (last_c) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Check each result transaction.
  always @(posedge clk_i) begin : check_results
    line_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_lines.size() == 0) begin
        $error("result transaction with no line expected");
        fail_count++;
      end else begin
        want = expected_lines.pop_front();
        check_field("found",     want.found,     m_axis_tdata[0]);
        check_field("first_row", want.first_row, m_axis_tdata[1 +: COORD_W]);
        check_field("first_col", want.first_col, m_axis_tdata[11 +: COORD_W]);
        check_field("end_row",   want.end_row,   m_axis_tdata[21 +: COORD_W]);
        check_field("end_col",   want.end_col,   m_axis_tdata[31 +: COORD_W]);
      end
    end
  end

  // Drive the receiver's ready: count down a hold-off, else stall at random.
  always @(posedge clk_i) begin : drive_ready
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(input logic p);
    line_result_t line;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(p);
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    if (track_pixel(p, line)) expected_lines.push_back(line);
  endtask

  task automatic send_bits(input logic [63:0] bits, input int n);
    for (int i = 0; i < n; i++) send_pixel(bits[i]);
  endtask

  task automatic send_pixels(input int n, input int density);
    for (int i = 0; i < n; i++) send_pixel($urandom_range(99) < density);
  endtask

  task automatic send_frame(input int density);
    int n;
    n = eff_size(width_cfg, MAX_WIDTH) * eff_size(height_cfg, MAX_HEIGHT);
    send_pixels(n, density);
  endtask

  // Drop valid, drain outstanding lines, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DIRECTION: dir_mode   = val[0];
      CFG_WIDTH:     width_cfg  = val;
      CFG_HEIGHT:    height_cfg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int dir, input int w, input int h);
    wait_idle();
    write_reg(CFG_DIRECTION, CFG_DATA_W'(dir));
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    cfg_valid_i <= 1'b0;
  endtask

  // Single pixels, row ties, column ties and runs touching the frame edges.
  task automatic test_directed_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(0, 1, 1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    configure(1, 1, 1);
    send_pixel(1'b1);
    // rows 0110 / 0011 / 1000: equal runs, first one in row order wins
    configure(0, 4, 3);
    send_bits(64'h1C6, 12);
    // columns: col 2 rows 0-1 ends first, col 0 rows 2-3 ties later and wins
    configure(1, 3, 4);
    send_bits(64'h264, 12);
  endtask

  // Zero and oversized sizes that clamp, sizes cut mid-frame, mode change mid-frame.
  task automatic test_size_extremes();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    // oversized width clamps; shrinking it ends the row and the frame at once
    configure(0, 2047, 0);
    send_pixels(30, 80);
    configure(0, 20, 0);
    send_pixels(1, 80);
    configure(1, 0, 2047);
    send_pixels(30, 80);
    configure(1, 0, 20);
    send_pixels(1, 80);
    configure(1, 20, 2);
    send_frame(50);
    // switch to columns partway; the end point follows the final mode
    configure(0, 8, 4);
    send_pixels(20, 70);
    configure(1, 8, 4);
    send_pixels(12, 70);
  endtask

  task automatic test_random_frames();
    int send_pcts [4] = '{0, 61, 0, 22};
    int recv_pcts [4] = '{0, 0, 61, 22};
    int goal;
    int w, h;
    int density;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      goal = pixels_sent + 100;
      while (pixels_sent < goal) begin
        w = ($urandom_range(9) == 0) ? int'($urandom_range(9, 40)) : int'($urandom_range(0, 8));
        h = ($urandom_range(9) == 0) ? int'($urandom_range(9, 16)) : int'($urandom_range(0, 6));
        configure(int'($urandom_range(1)), w, h);
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(5))
            0: density = 0;
            1: density = 100;
            default: density = $urandom_range(10, 95);
          endcase
          send_frame(density);
        end
      end
    end
  endtask

  // Long receiver hold-off fills the block, then a sender pause drains it.
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(int'($urandom_range(1)), 2, 1);
    hold_left = 150;
    repeat (30) send_frame(60);
    s_axis_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    recv_stall_pct = 61;
    repeat (20) send_frame(60);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_DIRECTION;
    cfg_data_i     = '0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    pixels_sent    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_size_extremes();
    test_random_frames();
    test_output_stall();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
